[hw/rtl/mrfc_pkg.sv]
package mrfc_pkg;

  localparam int MaxFrameBytes = 255;

  localparam logic [1:0] OP_FRAME      = 2'd0;
  localparam logic [1:0] OP_CONNECT    = 2'd1;
  localparam logic [1:0] OP_DISCONNECT = 2'd2;

  localparam logic [3:0] VERD_SHORT   = 4'd0;
  localparam logic [3:0] VERD_CRC_ERR = 4'd1;
  localparam logic [3:0] VERD_ACK     = 4'd2;
  localparam logic [3:0] VERD_RTS     = 4'd3;
  localparam logic [3:0] VERD_CTS     = 4'd4;
  localparam logic [3:0] VERD_END     = 4'd5;
  localparam logic [3:0] VERD_DATA    = 4'd6;
  localparam logic [3:0] VERD_DUP     = 4'd7;
  localparam logic [3:0] VERD_BCAST   = 4'd8;
  localparam logic [3:0] VERD_IGNORED = 4'd9;

  localparam logic [7:0]  TYPE_ACK    = 8'h02;
  localparam logic [7:0]  CMD_RTS     = 8'h01;
  localparam logic [7:0]  CMD_CTS     = 8'h02;
  localparam logic [7:0]  CMD_END     = 8'h03;
  localparam logic [7:0]  CMD_REALIGN = 8'h08;
  localparam logic [15:0] BCAST_ADDR  = 16'hFFFF;
  localparam logic [7:0]  MIN_LEN     = 8'd12;
  localparam logic [7:0]  ACK_LEN     = 8'd6;
  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [15:0] OWN_ADDR_RST = 16'hE841;
  localparam logic [7:0]  MAX_COUNT   = 8'(MaxFrameBytes);

  // Register byte addresses (word index in paddr[2])
  localparam logic REG_OWN_ADDRESS = 1'b0;

  // Frame fields gathered so far, as seen at the trailer byte
  typedef struct packed {
    logic        crc_ok;
    logic [7:0]  len;
    logic [7:0]  type_byte;
    logic [7:0]  seq_byte;
    logic [15:0] dest_addr;
    logic [15:0] src_addr;
    logic [7:0]  command_byte;
  } frame_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [7:0]  seq_number;
    logic        ack_needed;
    logic [7:0]  payload_length;
    logic [15:0] link_peer;
    logic [15:0] error_total;
    logic [15:0] accepted_total;
  } result_t;

  // Reflected CRC-16, one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb = b[k] ^ c[0];
      c  = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c != 16'hFFFF) ? c + 16'd1 : c;
  endfunction

endpackage

[hw/rtl/mrfc_frame.sv]
module mrfc_frame (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [1:0]         op,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output mrfc_pkg::frame_t   frame
);

  logic [15:0] crc_reg;
  logic [7:0]  byte_count;
  logic [7:0]  type_byte;
  logic [7:0]  seq_byte;
  logic [15:0] dest_addr;
  logic [15:0] src_addr;
  logic [7:0]  command_byte;
  logic [8:0]  len_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg      <= '0;
      byte_count   <= '0;
      type_byte    <= '0;
      seq_byte     <= '0;
      dest_addr    <= '0;
      src_addr     <= '0;
      command_byte <= '0;
    end else if (fire && op == mrfc_pkg::OP_FRAME) begin
      if (last_byte) begin
        crc_reg      <= '0;
        byte_count   <= '0;
        type_byte    <= '0;
        seq_byte     <= '0;
        dest_addr    <= '0;
        src_addr     <= '0;
        command_byte <= '0;
      end else begin
        crc_reg <= mrfc_pkg::crc_byte(crc_reg, data_byte);
        unique case (byte_count)
          8'd0: type_byte <= data_byte;
          8'd2: seq_byte <= data_byte;
          8'd5: dest_addr[7:0] <= data_byte;
          8'd6: dest_addr[15:8] <= data_byte;
          8'd7: src_addr[7:0] <= data_byte;
          8'd8: src_addr[15:8] <= data_byte;
          8'd9: command_byte <= data_byte;
          default: ;
        endcase
        if (byte_count < mrfc_pkg::MAX_COUNT) begin
          byte_count <= byte_count + 8'd1;
        end
      end
    end
  end

  // length with trailer, clamped to the frame limit
  assign len_wide = {1'b0, byte_count} + 9'd1;

  always_comb begin
    frame.crc_ok       = (crc_reg == 16'd0);
    frame.len          = (len_wide > {1'b0, mrfc_pkg::MAX_COUNT}) ? mrfc_pkg::MAX_COUNT
                                                                 : len_wide[7:0];
    frame.type_byte    = type_byte;
    frame.seq_byte     = seq_byte;
    frame.dest_addr    = dest_addr;
    frame.src_addr     = src_addr;
    frame.command_byte = command_byte;
  end

endmodule

[hw/rtl/mrfc_link.sv]
module mrfc_link (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [1:0]         op,
  input  logic               last_byte,
  input  logic [15:0]        peer_request,
  input  logic [15:0]        own_address,
  input  mrfc_pkg::frame_t   frame,
  output logic               res_valid,
  output mrfc_pkg::result_t  res
);

  logic        connected;
  logic [15:0] peer_addr;
  logic [7:0]  last_seq;
  logic        last_seq_valid;
  logic [15:0] error_count;
  logic [15:0] accept_count;

  logic        connected_next;
  logic [15:0] peer_addr_next;
  logic [7:0]  last_seq_next;
  logic        last_seq_valid_next;
  logic [15:0] error_count_next;
  logic [15:0] accept_count_next;

  logic [3:0]  verd;
  logic        ack;
  logic [7:0]  payload;
  logic        for_me;
  logic        from_peer;
  logic        not_bcast;
  logic        is_short;
  logic        trailer;

  assign for_me    = (frame.src_addr != own_address) && (frame.dest_addr == own_address);
  assign from_peer = (peer_addr == frame.src_addr);
  assign not_bcast = (frame.dest_addr != mrfc_pkg::BCAST_ADDR);
  assign is_short  = (frame.len < mrfc_pkg::MIN_LEN) && (frame.len != mrfc_pkg::ACK_LEN);
  assign trailer   = fire && (op == mrfc_pkg::OP_FRAME) && last_byte;

  always_comb begin
    connected_next      = connected;
    peer_addr_next      = peer_addr;
    last_seq_next       = last_seq;
    last_seq_valid_next = last_seq_valid;
    error_count_next    = error_count;
    accept_count_next   = accept_count;
    verd                = mrfc_pkg::VERD_IGNORED;
    ack                 = 1'b0;
    payload             = 8'd0;
    if (fire && op == mrfc_pkg::OP_CONNECT) begin
      peer_addr_next = peer_request;
    end else if (fire && op == mrfc_pkg::OP_DISCONNECT) begin
      peer_addr_next      = '0;
      connected_next      = 1'b0;
      last_seq_next       = '0;
      last_seq_valid_next = 1'b0;
    end else if (trailer) begin
      priority if (is_short) begin
        verd = mrfc_pkg::VERD_SHORT;
      end else if (!frame.crc_ok) begin
        verd             = mrfc_pkg::VERD_CRC_ERR;
        error_count_next = mrfc_pkg::sat_inc(error_count);
      end else if (frame.type_byte == mrfc_pkg::TYPE_ACK) begin
        verd = mrfc_pkg::VERD_ACK;
      end else if (for_me && frame.command_byte == mrfc_pkg::CMD_RTS &&
                   (!connected || from_peer)) begin
        verd           = mrfc_pkg::VERD_RTS;
        peer_addr_next = frame.src_addr;
        connected_next = 1'b1;
        ack            = not_bcast;
      end else if (for_me && frame.command_byte == mrfc_pkg::CMD_CTS) begin
        verd              = mrfc_pkg::VERD_CTS;
        connected_next    = 1'b1;
        accept_count_next = mrfc_pkg::sat_inc(accept_count);
        ack               = not_bcast;
      end else if (for_me && frame.command_byte == mrfc_pkg::CMD_END) begin
        verd = mrfc_pkg::VERD_END;
        ack  = not_bcast;
      end else if (for_me && from_peer && frame.command_byte != mrfc_pkg::CMD_RTS &&
                   frame.command_byte != mrfc_pkg::CMD_CTS) begin
        if (last_seq_valid && last_seq == frame.seq_byte) begin
          verd = mrfc_pkg::VERD_DUP;
        end else begin
          verd                = mrfc_pkg::VERD_DATA;
          last_seq_next       = frame.seq_byte;
          last_seq_valid_next = 1'b1;
          accept_count_next   = mrfc_pkg::sat_inc(accept_count);
          payload             = (frame.len > mrfc_pkg::MIN_LEN) ?
                                frame.len - mrfc_pkg::MIN_LEN : 8'd0;
        end
        ack = not_bcast;
      end else if (frame.dest_addr == mrfc_pkg::BCAST_ADDR &&
                   frame.command_byte == mrfc_pkg::CMD_REALIGN) begin
        verd = mrfc_pkg::VERD_BCAST;
      end else begin
        verd = mrfc_pkg::VERD_IGNORED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connected      <= 1'b0;
      peer_addr      <= '0;
      last_seq       <= '0;
      last_seq_valid <= 1'b0;
      error_count    <= '0;
      accept_count   <= '0;
    end else begin
      connected      <= connected_next;
      peer_addr      <= peer_addr_next;
      last_seq       <= last_seq_next;
      last_seq_valid <= last_seq_valid_next;
      error_count    <= error_count_next;
      accept_count   <= accept_count_next;
    end
  end

  assign res_valid = trailer;

  always_comb begin
    res.verdict        = verd;
    res.seq_number     = frame.seq_byte;
    res.ack_needed     = ack;
    res.payload_length = payload;
    res.link_peer      = peer_addr_next;
    res.error_total    = error_count_next;
    res.accepted_total = accept_count_next;
  end

  a_disc_clears: assert property (@(posedge clk) disable iff (rst)
    fire && op == mrfc_pkg::OP_DISCONNECT |=> !connected && !last_seq_valid && peer_addr == 16'd0)
    else $error("disconnect left link state");

  a_err_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> error_count >= $past(error_count))
    else $error("error count went backwards");

  a_accept_only_cts_data: assert property (@(posedge clk) disable iff (rst)
    accept_count_next != accept_count |->
      trailer && (verd == mrfc_pkg::VERD_CTS || verd == mrfc_pkg::VERD_DATA))
    else $error("accept count moved without cts or data");

endmodule

[hw/rtl/mac_rx_frame_classifier_unit.sv]
// Receive-side frame classifier for an 802.15.4-style MAC.
//
// Item channel (item_valid / item_stall): one transaction per frame byte
// (op = frame byte, last_byte marks the trailer) or per local connect /
// disconnect request. Result channel (result_valid / result_stall): one
// transaction per trailer byte carrying the verdict, ack flag, payload
// length, current peer and the saturating error / accept counters.
//
// Pipeline: input register -> CRC/capture and classify logic -> result
// register. A trailer taken into the input register is classified and its
// result is loaded into the result register, where result_valid shows it. One
// transaction per cycle is sustained while the result channel is not stalled;
// the CRC byte update and the verdict priority chain are both combinational.
//
// When the result register is full and stalled, the input register holds its
// item and item_stall goes high until the result is taken; nothing is dropped.
// Reset clears the frame state, link state and counters and sets own_address to
// 0xE841. The user must write configuration over APB only while idle, which the block does not enforce.
module mac_rx_frame_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [15:0] peer_request,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  verdict,
  output logic [7:0]  seq_number,
  output logic        ack_needed,
  output logic [7:0]  payload_length,
  output logic [15:0] link_peer,
  output logic [15:0] error_total,
  output logic [15:0] accepted_total,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // input register
  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [7:0]  s1_data;
  logic        s1_last;
  logic [15:0] s1_peer;

  logic        proc_fire;
  logic        item_take;
  logic        load_result;
  logic [15:0] own_address;

  mrfc_pkg::frame_t  frame;
  mrfc_pkg::result_t res;
  logic              res_valid;

  // processing stage advances when the result register is free or draining
  assign proc_fire  = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !proc_fire;
  assign item_take  = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (proc_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_op   <= op;
      s1_data <= data_byte;
      s1_last <= last_byte;
      s1_peer <= peer_request;
    end
  end

  // APB register: own_address at word 0
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= mrfc_pkg::OWN_ADDR_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mrfc_pkg::REG_OWN_ADDRESS) begin
      own_address <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == mrfc_pkg::REG_OWN_ADDRESS) ? {16'd0, own_address} : 32'd0;

  mrfc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .fire      (proc_fire),
    .op        (s1_op),
    .data_byte (s1_data),
    .last_byte (s1_last),
    .frame     (frame)
  );

  mrfc_link u_link (
    .clk          (clk),
    .rst          (rst),
    .fire         (proc_fire),
    .op           (s1_op),
    .last_byte    (s1_last),
    .peer_request (s1_peer),
    .own_address  (own_address),
    .frame        (frame),
    .res_valid    (res_valid),
    .res          (res)
  );

  // result register
  assign load_result = proc_fire && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      verdict        <= res.verdict;
      seq_number     <= res.seq_number;
      ack_needed     <= res.ack_needed;
      payload_length <= res.payload_length;
      link_peer      <= res.link_peer;
      error_total    <= res.error_total;
      accepted_total <= res.accepted_total;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid && result_stall)
    else $error("input stalled without a blocked result");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load_result |=> result_valid)
    else $error("classified trailer produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !load_result)
    else $error("stalled result overwritten");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

localparam logic [1:0] OP_UNUSED = 2'd3;

// byte positions captured from the frame header
localparam int POS_TYPE    = 0;
localparam int POS_SEQ     = 2;
localparam int POS_DEST_LO = 5;
localparam int POS_DEST_HI = 6;
localparam int POS_SRC_LO  = 7;
localparam int POS_SRC_HI  = 8;
localparam int POS_CMD     = 9;

localparam logic [7:0] FRAME_TYPE_DATA = 8'h41;

// Link-state predictor plus the queue of verdicts still owed by the block.
class rx_verdict_book;
  logic [15:0] own_addr;
  logic [15:0] crc;
  logic [7:0]  count;
  logic [7:0]  ftype;
  logic [7:0]  fseq;
  logic [7:0]  cmd;
  logic [15:0] dest;
  logic [15:0] src;
  bit          linked;
  logic [15:0] peer;
  logic [7:0]  last_seq;
  bit          seq_valid;
  logic [15:0] crc_errors;
  logic [15:0] accepts;
  mrfc_pkg::result_t awaited[$];
  int          fails;

  function new();
    own_addr   = mrfc_pkg::OWN_ADDR_RST;
    linked     = 0;
    peer       = '0;
    last_seq   = '0;
    seq_valid  = 0;
    crc_errors = '0;
    accepts    = '0;
    fails      = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    crc   = '0;
    count = '0;
    ftype = '0;
    fseq  = '0;
    dest  = '0;
    src   = '0;
    cmd   = '0;
  endfunction

  // reflected CRC-16, byte folded in first, then shifted out LSB first
  static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ mrfc_pkg::CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  function void classify_item(logic [1:0] o, logic [7:0] b, logic l, logic [15:0] req);
    mrfc_pkg::result_t r;
    logic [8:0] flen;
    logic for_me;
    logic from_peer;
    logic not_bcast;
    r = '0;
    case (o)
      mrfc_pkg::OP_CONNECT: begin
        peer = req;
      end
      mrfc_pkg::OP_DISCONNECT: begin
        peer      = '0;
        linked    = 0;
        last_seq  = '0;
        seq_valid = 0;
      end
      mrfc_pkg::OP_FRAME: begin
        if (!l) begin
          crc = crc_step(crc, b);
          case (int'(count))
            POS_TYPE:    ftype = b;
            POS_SEQ:     fseq = b;
            POS_DEST_LO: dest[7:0] = b;
            POS_DEST_HI: dest[15:8] = b;
            POS_SRC_LO:  src[7:0] = b;
            POS_SRC_HI:  src[15:8] = b;
            POS_CMD:     cmd = b;
            default: ;
          endcase
          if (count < mrfc_pkg::MAX_COUNT) count++;
        end else begin
          flen = {1'b0, count} + 9'd1;
          if (flen > {1'b0, mrfc_pkg::MAX_COUNT}) flen = {1'b0, mrfc_pkg::MAX_COUNT};
          for_me    = (src != own_addr) && (dest == own_addr);
          from_peer = (peer == src);
          not_bcast = (dest != mrfc_pkg::BCAST_ADDR);
          if (flen < {1'b0, mrfc_pkg::MIN_LEN} && flen != {1'b0, mrfc_pkg::ACK_LEN}) begin
            r.verdict = mrfc_pkg::VERD_SHORT;
          end else if (crc != '0) begin
            r.verdict = mrfc_pkg::VERD_CRC_ERR;
            if (~&crc_errors) crc_errors++;
          end else if (ftype == mrfc_pkg::TYPE_ACK) begin
            r.verdict = mrfc_pkg::VERD_ACK;
          end else if (for_me && cmd == mrfc_pkg::CMD_RTS && (!linked || from_peer)) begin
            r.verdict    = mrfc_pkg::VERD_RTS;
            peer         = src;
            linked       = 1;
            r.ack_needed = not_bcast;
          end else if (for_me && cmd == mrfc_pkg::CMD_CTS) begin
            r.verdict    = mrfc_pkg::VERD_CTS;
            linked       = 1;
            if (~&accepts) accepts++;
            r.ack_needed = not_bcast;
          end else if (for_me && cmd == mrfc_pkg::CMD_END) begin
            r.verdict    = mrfc_pkg::VERD_END;
            r.ack_needed = not_bcast;
          end else if (for_me && from_peer && cmd != mrfc_pkg::CMD_RTS &&
                       cmd != mrfc_pkg::CMD_CTS) begin
            if (seq_valid && last_seq == fseq) begin
              r.verdict = mrfc_pkg::VERD_DUP;
            end else begin
              r.verdict = mrfc_pkg::VERD_DATA;
              last_seq  = fseq;
              seq_valid = 1;
              if (~&accepts) accepts++;
              r.payload_length = (flen > {1'b0, mrfc_pkg::MIN_LEN}) ?
                                 8'(flen - {1'b0, mrfc_pkg::MIN_LEN}) : 8'd0;
            end
            r.ack_needed = not_bcast;
          end else if (dest == mrfc_pkg::BCAST_ADDR && cmd == mrfc_pkg::CMD_REALIGN) begin
            r.verdict = mrfc_pkg::VERD_BCAST;
          end else begin
            r.verdict = mrfc_pkg::VERD_IGNORED;
          end
          r.seq_number     = fseq;
          r.link_peer      = peer;
          r.error_total    = crc_errors;
          r.accepted_total = accepts;
          awaited.insert(awaited.size(), r);
          clear_frame();
        end
      end
      default: ;
    endcase
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  task check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task match_verdict(mrfc_pkg::result_t got);
    mrfc_pkg::result_t want;
    if (awaited.size() == 0) begin
      report_mismatch("result with no verdict pending");
      return;
    end
    want = awaited.pop_front();
    check_field("verdict", 16'(got.verdict), 16'(want.verdict));
    check_field("seq_number", 16'(got.seq_number), 16'(want.seq_number));
    check_field("ack_needed", 16'(got.ack_needed), 16'(want.ack_needed));
    check_field("payload_length", 16'(got.payload_length), 16'(want.payload_length));
    check_field("link_peer", got.link_peer, want.link_peer);
    check_field("error_total", got.error_total, want.error_total);
    check_field("accepted_total", got.accepted_total, want.accepted_total);
  endtask
endclass

module tb;
  localparam logic [2:0] OWN_ADDR_BYTE = {mrfc_pkg::REG_OWN_ADDRESS, 2'b00};

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [1:0]  op;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] peer_request;
  logic        result_valid;
  logic        result_stall;
  logic [3:0]  verdict;
  logic [7:0]  seq_number;
  logic        ack_needed;
  logic [7:0]  payload_length;
  logic [15:0] link_peer;
  logic [15:0] error_total;
  logic [15:0] accepted_total;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rx_verdict_book book;
  int          items_sent;
  bit          rush;       // sender skips its idle gaps
  bit          long_hold;  // asks the receiver for one long hold-off
  logic [7:0]  frame_bytes[$];

  mac_rx_frame_classifier_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .op             (op),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .peer_request   (peer_request),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .verdict        (verdict),
    .seq_number     (seq_number),
    .ack_needed     (ack_needed),
    .payload_length (payload_length),
    .link_peer      (link_peer),
    .error_total    (error_total),
    .accepted_total (accepted_total),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: draws a random stall length per transaction, sometimes runs
  // a stretch with no stall, and once, on long_hold, holds off so the block
  // backs up into its item channel.
  initial begin
    int hold;
    int fast_left;
    bit was_long;
    mrfc_pkg::result_t got;
    result_stall = 1'b0;
    fast_left    = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      was_long = long_hold;
      if (was_long) begin
        hold = 200;
      end else if (fast_left > 0) begin
        hold = 0;
        fast_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        hold      = 0;
        fast_left = 12;
      end else begin
        hold = $urandom_range(0, 11);
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        if (was_long) long_hold = 0;
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      got.verdict        = verdict;
      got.seq_number     = seq_number;
      got.ack_needed     = ack_needed;
      got.payload_length = payload_length;
      got.link_peer      = link_peer;
      got.error_total    = error_total;
      got.accepted_total = accepted_total;
      book.match_verdict(got);
      @(negedge clk);
    end
  end

  // One item transaction: optional idle gap, then hold the payload until taken.
  // Payload changes only at falling edges; acceptance is seen at the rising edge.
  task automatic send_item(input logic [1:0] o, input logic [7:0] b, input logic l,
                           input logic [15:0] req);
    int gap;
    gap = (rush || long_hold) ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid   <= 1'b1;
    op           <= o;
    data_byte    <= b;
    last_byte    <= l;
    peer_request <= req;
    do @(posedge clk); while (item_stall);
    book.classify_item(o, b, l, req);
    items_sent++;
  endtask

  task automatic idle_items();
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  // Wait for every pending verdict, then let the pipeline settle.
  task automatic drain();
    while (book.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic [15:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OWN_ADDR_BYTE;
    pwdata  <= {16'h0000, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    book.own_addr = v;
  endtask

  task automatic apb_read_check();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= OWN_ADDR_BYTE;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    book.check_field("own_address readback", prdata[15:0], book.own_addr);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void add_byte(input logic [7:0] v);
    frame_bytes.insert(frame_bytes.size(), v);
  endfunction

  // Likely peers get picked often so RTS/data exchanges actually line up.
  function automatic logic [15:0] pick_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'h1234;
    if (r < 7) return 16'hBEEF;
    return 16'($urandom);
  endfunction

  task automatic send_local();
    case ($urandom_range(0, 2))
      0: send_item(mrfc_pkg::OP_CONNECT, 8'($urandom), 1'($urandom), pick_addr());
      1: send_item(mrfc_pkg::OP_DISCONNECT, 8'($urandom), 1'($urandom), 16'($urandom));
      default: send_item(OP_UNUSED, 8'($urandom), 1'($urandom), 16'($urandom));
    endcase
  endtask

  // Sends frame_bytes then a trailer; noisy frames get local requests mixed in.
  task automatic send_body(input bit noisy);
    foreach (frame_bytes[i]) begin
      if (noisy && $urandom_range(0, 39) == 0) send_local();
      send_item(mrfc_pkg::OP_FRAME, frame_bytes[i], 1'b0, 16'($urandom));
    end
    send_item(mrfc_pkg::OP_FRAME, 8'($urandom), 1'b1, 16'($urandom));
    frame_bytes.delete();
  endtask

  // Appends the CRC so the residue at the trailer is zero, optionally flips a bit.
  task automatic seal_and_send(input bit corrupt, input bit noisy);
    logic [15:0] c;
    int idx;
    c = '0;
    foreach (frame_bytes[i]) c = book.crc_step(c, frame_bytes[i]);
    add_byte(c[7:0]);
    add_byte(c[15:8]);
    if (corrupt) begin
      idx = $urandom_range(0, frame_bytes.size() - 1);
      frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
    send_body(noisy);
  endtask

  task automatic put_header(input logic [7:0] t, input logic [7:0] s, input logic [15:0] d,
                            input logic [15:0] sa, input logic [7:0] c);
    add_byte(t);
    add_byte(8'($urandom));
    add_byte(s);
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    add_byte(d[7:0]);
    add_byte(d[15:8]);
    add_byte(sa[7:0]);
    add_byte(sa[15:8]);
    add_byte(c);
  endtask

  // Well-formed frame with random content biased toward the link handshake.
  task automatic random_frame(input bit corrupt, input int pay);
    logic [7:0]  t;
    logic [7:0]  s;
    logic [15:0] d;
    logic [15:0] sa;
    logic [7:0]  c;
    int r;
    r = $urandom_range(0, 9);
    t = (r == 0) ? mrfc_pkg::TYPE_ACK : (r == 1) ? 8'($urandom) : FRAME_TYPE_DATA;
    s = ($urandom_range(0, 2) == 0) ? book.last_seq : 8'($urandom);
    r = $urandom_range(0, 19);
    d = (r < 13) ? book.own_addr : (r < 17) ? mrfc_pkg::BCAST_ADDR : 16'($urandom);
    r = $urandom_range(0, 19);
    sa = (r < 9) ? book.peer : (r < 14) ? pick_addr() : (r < 16) ? book.own_addr
                                                               : 16'($urandom);
    r = $urandom_range(0, 19);
    c = (r < 5) ? mrfc_pkg::CMD_RTS : (r < 8) ? mrfc_pkg::CMD_CTS :
        (r < 10) ? mrfc_pkg::CMD_END : (r < 12) ? mrfc_pkg::CMD_REALIGN : 8'($urandom);
    put_header(t, s, d, sa, c);
    repeat (pay) add_byte(8'($urandom));
    // now and then drop the command byte: minimum length with a good CRC
    if (pay == 0 && $urandom_range(0, 9) == 0) void'(frame_bytes.pop_back());
    seal_and_send(corrupt, 1'b1);
  endtask

  task automatic random_action();
    int r;
    int n;
    rush = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 65) begin
      random_frame(1'b0, ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(0, 8));
    end else if (r < 73) begin
      random_frame(1'b1, $urandom_range(0, 8));
    end else if (r < 79) begin
      // runt or garbage without a CRC
      n = $urandom_range(0, 11);
      repeat (n) add_byte(8'($urandom));
      send_body(1'b1);
    end else if (r < 85) begin
      // six-byte ack frame
      add_byte(mrfc_pkg::TYPE_ACK);
      add_byte(8'($urandom));
      add_byte(($urandom_range(0, 1) == 0) ? book.last_seq : 8'($urandom));
      seal_and_send($urandom_range(0, 5) == 0, 1'b0);
    end else begin
      send_local();
    end
  endtask

  // Main sequence: reset, then five configuration phases. Phase 0 opens with a
  // short directed list; every phase then runs random frames. own_address goes
  // through its reset value, both extremes and two random values.
  initial begin
    logic [15:0] own_val;
    int target;
    book         = new();
    items_sent   = 0;
    rush         = 0;
    long_hold    = 0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    op           = mrfc_pkg::OP_FRAME;
    data_byte    = '0;
    last_byte    = 1'b0;
    peer_request = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = OWN_ADDR_BYTE;
    pwdata       = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apb_read_check();  // reset value
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: own_val = mrfc_pkg::OWN_ADDR_RST;
        1: own_val = 16'h0000;
        2: own_val = 16'hFFFF;
        default: own_val = 16'($urandom);
      endcase
      if (p > 0) begin
        idle_items();
        drain();
      end
      apb_write(own_val);
      apb_read_check();

      if (p == 0) begin
        // lone trailer (shortest runt), unused op, connect/disconnect,
        // an ack frame with top-value bytes, an RTS with no payload
        send_item(mrfc_pkg::OP_FRAME, 8'hFF, 1'b1, 16'hFFFF);
        send_item(OP_UNUSED, 8'hFF, 1'b1, 16'hFFFF);
        send_item(mrfc_pkg::OP_CONNECT, 8'h00, 1'b0, 16'hFFFF);
        send_item(mrfc_pkg::OP_DISCONNECT, 8'h00, 1'b1, 16'h0000);
        add_byte(mrfc_pkg::TYPE_ACK);
        add_byte(8'hFF);
        add_byte(8'hFF);
        seal_and_send(1'b0, 1'b0);
        put_header(FRAME_TYPE_DATA, 8'h00, book.own_addr, 16'h1234, mrfc_pkg::CMD_RTS);
        seal_and_send(1'b0, 1'b0);
      end
      if (p == 1) begin
        // over-long frame: byte count saturates, CRC still covers every byte
        rush = 1;
        random_frame(1'b0, $urandom_range(250, 280));
      end
      if (p == 3) long_hold = 1;

      target = items_sent + 112;
      while (items_sent < target) random_action();
    end

    idle_items();
    drain();
    if (book.awaited.size() != 0) book.report_mismatch("verdicts still pending at end");
    if (book.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
